// ===== hw/rtl/i2f_pkg.sv =====
// ============================================================================
// i2f_pkg: shared types and constants of the int-times-pow2 to float32 core
// Holds the stage payload types passed between modules, the IEEE-754 single
// precision field constants and the leading-zero count function.
// ============================================================================
`default_nettype none

package i2f_pkg;

    localparam int FRAC_BITS = 23;
    localparam int EXP_BIAS  = 127;

    localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
    localparam logic [31:0] FRAC_MASK = 32'h007f_ffff;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

    // Right shift that keeps a normal significand: 32-bit word down to 24 bits.
    localparam int NORM_SHIFT = 31 - FRAC_BITS;
    // Any larger right shift leaves nothing but rounding towards zero.
    localparam int MAX_SHIFT  = 33;

    // Leading-zero stage output
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic signed [9:0] exp;
        logic [31:0]       mag;
        logic [4:0]        lz;
    } i2f_lead_t;

    // Rounding stage output
    typedef struct packed {
        logic        sign;
        logic        zero;
        logic [9:0]  bexp;   // biased exponent minus one, zero for subnormals
        logic [23:0] quo;    // truncated significand including the hidden bit
        logic        inc;    // round-to-nearest-even increment
    } i2f_rnd_t;

    // Leading-zero count as a five-step binary search
    function automatic logic [4:0] clz32(input logic [31:0] x);
        logic [31:0] v;
        logic [4:0]  n;
        v = x;
        n = '0;
        if (v[31:16] == 16'h0)
        begin
            n[4] = 1'b1;
            v    = {v[15:0], 16'h0};
        end
        if (v[31:24] == 8'h0)
        begin
            n[3] = 1'b1;
            v    = {v[23:0], 8'h0};
        end
        if (v[31:28] == 4'h0)
        begin
            n[2] = 1'b1;
            v    = {v[27:0], 4'h0};
        end
        if (v[31:30] == 2'h0)
        begin
            n[1] = 1'b1;
            v    = {v[29:0], 2'h0};
        end
        if (v[31] == 1'b0)
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2f_front.sv =====
// ============================================================================
// i2f_front: magnitude and leading-zero stages
// Stage one splits the integer into sign and magnitude; stage two counts the
// leading zeros of the magnitude.
// ============================================================================
`default_nettype none

module i2f_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           int_value,
    input  wire logic [9:0]            pow2_exponent,
    output logic                       lead_valid,
    input  wire logic                  lead_ready,
    output i2f_pkg::i2f_lead_t         lead
);

    logic              vld1_reg;
    logic              sign1_reg, sign1_next;
    logic              zero1_reg, zero1_next;
    logic signed [9:0] exp1_reg, exp1_next;
    logic [31:0]       mag1_reg, mag1_next;
    logic              vld2_reg;
    i2f_pkg::i2f_lead_t lead_reg, lead_next;
    logic              adv1;
    logic              adv2;

    // Advance a stage when it is empty or its item moves on
    assign adv2     = !vld2_reg || lead_ready;
    assign adv1     = !vld1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        sign1_next = int_value[31];
        zero1_next = (int_value == 32'h0);
        exp1_next  = $signed(pow2_exponent);
        mag1_next  = int_value[31] ? (~int_value + 32'd1) : int_value;
    end

    always_comb
    begin
        lead_next.sign = sign1_reg;
        lead_next.zero = zero1_reg;
        lead_next.exp  = exp1_reg;
        lead_next.mag  = mag1_reg;
        lead_next.lz   = i2f_pkg::clz32(mag1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                vld1_reg <= in_valid;
            end
            if (adv2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            sign1_reg <= sign1_next;
            zero1_reg <= zero1_next;
            exp1_reg  <= exp1_next;
            mag1_reg  <= mag1_next;
        end
        if (adv2 && vld1_reg)
        begin
            lead_reg <= lead_next;
        end
    end

    assign lead_valid = vld2_reg;
    assign lead       = lead_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/i2f_round.sv =====
// ============================================================================
// i2f_round: normalise and round stages
// Stage three normalises the magnitude and works out the exponent and the
// right shift; stage four shifts and derives the round-to-nearest-even step.
// ============================================================================
`default_nettype none

module i2f_round
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  lead_valid,
    output logic                       lead_ready,
    input  wire i2f_pkg::i2f_lead_t    lead,
    output logic                       rnd_valid,
    input  wire logic                  rnd_ready,
    output i2f_pkg::i2f_rnd_t          rnd
);

    typedef struct packed {
        logic        sign;
        logic        zero;
        logic [31:0] norm;
        logic [9:0]  bexp;
        logic [5:0]  sh;
    } norm_t;

    localparam logic signed [10:0] TOP_EXP = 11'(31 + i2f_pkg::EXP_BIAS);

    logic              vld3_reg;
    norm_t             norm_reg, norm_next;
    logic              vld4_reg;
    i2f_pkg::i2f_rnd_t rnd_reg, rnd_next;
    logic              adv3;
    logic              adv4;
    logic signed [10:0] be;
    logic [64:0]       ext;
    logic              rbit;
    logic              sticky;

    assign adv4       = !vld4_reg || rnd_ready;
    assign adv3       = !vld3_reg || adv4;
    assign lead_ready = adv3;

    // Biased exponent of the value with its leading one at bit 31
    always_comb
    begin
        be = TOP_EXP - $signed({6'b0, lead.lz}) + $signed({lead.exp[9], lead.exp});
        norm_next.sign = lead.sign;
        norm_next.zero = lead.zero;
        norm_next.norm = lead.mag << lead.lz;
        norm_next.bexp = (be > 11'sd0) ? (be[9:0] - 10'd1) : 10'd0;
        priority if (be > 11'sd0)
        begin
            norm_next.sh = 6'(i2f_pkg::NORM_SHIFT);
        end
        else if (be < 11'(i2f_pkg::NORM_SHIFT + 1 - i2f_pkg::MAX_SHIFT))
        begin
            norm_next.sh = 6'(i2f_pkg::MAX_SHIFT);
        end
        else
        begin
            norm_next.sh = 6'(11'(i2f_pkg::NORM_SHIFT + 1) - be);
        end
    end

    // Keep every shifted-out bit below the significand for guard and sticky
    always_comb
    begin
        ext    = {norm_reg.norm, 33'h0} >> norm_reg.sh;
        rbit   = ext[32];
        sticky = |ext[31:0];
        rnd_next.sign = norm_reg.sign;
        rnd_next.zero = norm_reg.zero;
        rnd_next.bexp = norm_reg.bexp;
        rnd_next.quo  = ext[56:33];
        rnd_next.inc  = rbit && (sticky || ext[33]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                vld3_reg <= lead_valid;
            end
            if (adv4)
            begin
                vld4_reg <= vld3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && lead_valid)
        begin
            norm_reg <= norm_next;
        end
        if (adv4 && vld3_reg)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign rnd_valid = vld4_reg;
    assign rnd       = rnd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/i2f_pack.sv =====
// ============================================================================
// i2f_pack: rounding add and result packing
// Adds the rounding step to exponent and significand in one sum, saturates
// overflow to infinity and holds the result in the output register.
// ============================================================================
`default_nettype none

module i2f_pack
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rnd_valid,
    output logic                       rnd_ready,
    input  wire i2f_pkg::i2f_rnd_t     rnd,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                float_bits
);

    localparam logic [33:0] INF_LIMIT = {2'b00, i2f_pkg::EXP_MASK};

    logic        vld5_reg;
    logic [31:0] bits_reg, bits_next;
    logic        adv5;
    logic [33:0] sum;

    assign adv5      = !vld5_reg || out_ready;
    assign rnd_ready = adv5;

    // A carry out of the significand ripples into the exponent field
    always_comb
    begin
        sum = {1'b0, rnd.bexp, 23'h0} + {10'h0, rnd.quo} + {33'h0, rnd.inc};
        priority if (rnd.zero)
        begin
            bits_next = 32'h0;
        end
        else if (sum >= INF_LIMIT)
        begin
            bits_next = {rnd.sign, i2f_pkg::EXP_MASK[30:0]};
        end
        else
        begin
            bits_next = {rnd.sign, sum[30:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg <= 1'b0;
        end
        else if (adv5)
        begin
            vld5_reg <= rnd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv5 && rnd_valid)
        begin
            bits_reg <= bits_next;
        end
    end

    assign out_valid  = vld5_reg;
    assign float_bits = bits_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/int_times_pow2_to_float32_core.sv =====
// ============================================================================
// int_times_pow2_to_float32_core: signed integer times 2^n to IEEE-754 single
// Five-stage pipeline converting int_value * 2^pow2_exponent to a float32
// bit pattern, rounded to nearest even, with overflow saturating to infinity.
// ============================================================================
// Throughput is one item per clock while the output is not stalled. Each item
// passes through the five register stages (magnitude, leading-zero count,
// normalise, rounding shift, rounding add and pack) from accept to output.
// Each stage carries its own valid bit and advances whenever it is
// empty or its item moves on, so bubbles close up and a stall on the output
// holds every item in place without loss or repetition. Zero converts to +0
// whatever the exponent; the most negative integer is handled exactly; values
// below half the smallest subnormal round to a zero carrying the integer's
// sign; results too large for the format become signed infinity. No NaN is
// ever produced. The core has no configuration and no state beyond the
// pipeline registers.
`default_nettype none

module int_times_pow2_to_float32_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] int_value, [41:32] pow2_exponent
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] float_bits
);

    logic               lead_valid;
    logic               lead_ready;
    i2f_pkg::i2f_lead_t lead;
    logic               rnd_valid;
    logic               rnd_ready;
    i2f_pkg::i2f_rnd_t  rnd;

    // Sign/magnitude split and leading-zero count
    i2f_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .int_value     (s_axis_tdata[31:0]),
        .pow2_exponent (s_axis_tdata[41:32]),
        .lead_valid    (lead_valid),
        .lead_ready    (lead_ready),
        .lead          (lead)
    );

    // Normalise, pick the shift for normal or subnormal results, round
    i2f_round u_round
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .lead_valid (lead_valid),
        .lead_ready (lead_ready),
        .lead       (lead),
        .rnd_valid  (rnd_valid),
        .rnd_ready  (rnd_ready),
        .rnd        (rnd)
    );

    // Apply the rounding step, saturate and hold the result item
    i2f_pack u_pack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rnd_valid  (rnd_valid),
        .rnd_ready  (rnd_ready),
        .rnd        (rnd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .float_bits (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/i2f_checker.sv =====
// ============================================================================
// i2f_checker: port-level checks on the conversion core
// Watches the stream ports for stall behaviour, ready propagation, reset
// and illegal result encodings.
// ============================================================================
`default_nettype none

module i2f_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [47:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed or dropped");

    // A waiting input item holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("waiting input item changed or dropped");

    // A free output stage lets every stage advance, so input is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input not ready while output can drain");

    // Conversion never yields a NaN
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !((m_axis_tdata[30:23] == 8'hff) && (m_axis_tdata[22:0] != 23'h0)))
    else $error("result is a NaN");

    // Reset empties the pipeline
    assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind int_times_pow2_to_float32_core i2f_checker u_i2f_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ============================================================================
// tb: self-checking bench for int_times_pow2_to_float32_core
// Streams (int_value, pow2_exponent) items into the core and checks every
// float32 bit pattern that comes out against a behavioural converter kept in
// the bench. Covers zero, sign extremes, ties to even, subnormal rounding,
// the carry into the smallest normal and saturation to infinity, then runs
// random items under changing source gaps and sink back-pressure.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 100;
    // Source gap and sink stall rates in percent, one entry per random phase
    localparam int SRC_GAP_PCT[4]  = '{0, 84, 0, 22};
    localparam int SINK_STALL_PCT[4] = '{0, 0, 84, 22};
    // Cycles to wait after the last result; the core holds five stages
    localparam int SETTLE_CYCLES = 12;

    // One conversion request, laid out exactly as s_axis_tdata packs it
    typedef struct packed {
        logic signed [9:0]  pow2_exponent;
        logic signed [31:0] int_value;
    } conv_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // [31:0] int_value, [41:32] pow2_exponent
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] float_bits

    conv_req_t   pending_q[$];         // items waiting to be driven
    logic [31:0] float_expect_q[$];    // predicted float patterns, oldest first
    logic [31:0] want_bits;
    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    int_times_pow2_to_float32_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Converter model
    // ------------------------------------------------------------------------

    // Shift right by k, round to nearest, ties to even
    function automatic logic [63:0] shift_round_even(input logic [63:0] x, input int k);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (k == 0)
            return x;
        if (k >= 40)
            return 64'd0;
        q    = x >> k;
        rem  = x & ((64'd1 << k) - 64'd1);
        half = 64'd1 << (k - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    function automatic logic [31:0] to_float32_bits(input logic signed [31:0] ival,
                                                    input logic signed [9:0] pexp);
        logic        sgn;
        logic [31:0] mag;
        logic [63:0] sig;
        int          msb;
        int          bexp;
        int          sub_shift;
        if (ival == 32'sd0)
            return 32'h0;
        sgn = ival[31];
        // Two's complement negate; the most negative value gives 2^31 exactly
        mag = sgn ? (~$unsigned(ival) + 32'd1) : $unsigned(ival);
        msb = 0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                msb = i;
        bexp = msb + int'(pexp) + i2f_pkg::EXP_BIAS;
        if (bexp >= 1)
        begin
            if (msb > i2f_pkg::FRAC_BITS)
                sig = shift_round_even({32'd0, mag}, msb - i2f_pkg::FRAC_BITS);
            else
                sig = {32'd0, mag} << (i2f_pkg::FRAC_BITS - msb);
            // Rounding carried past the hidden bit: renormalise
            if (sig[i2f_pkg::FRAC_BITS + 1])
            begin
                sig  = sig >> 1;
                bexp = bexp + 1;
            end
            if (bexp >= 255)
                return i2f_pkg::SIGN_MASK & {sgn, 31'd0} | i2f_pkg::EXP_MASK;
            return {sgn, bexp[7:0], sig[22:0]};
        end
        // Subnormal: fraction is mag * 2^(pexp + 149); a carry lands on the
        // smallest normal, which the packing below gives for free
        sub_shift = int'(pexp) + i2f_pkg::EXP_BIAS - 1 + i2f_pkg::FRAC_BITS;
        if (sub_shift >= 0)
            sig = {32'd0, mag} << sub_shift;
        else
            sig = shift_round_even({32'd0, mag}, -sub_shift);
        return {sgn, sig[30:0]};
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_conversion(input logic signed [31:0] ival,
                                    input logic signed [9:0] pexp);
        conv_req_t r;
        r.int_value     = ival;
        r.pow2_exponent = pexp;
        pending_q.push_back(r);
    endtask

    // Random request, mostly aimed at the interesting exponent ranges
    function automatic conv_req_t draw_conversion();
        conv_req_t   r;
        int unsigned pick;
        int          width;
        int          target;
        int          e;
        logic [31:0] v;
        logic [31:0] low_mask;
        pick  = $urandom_range(0, 9);
        width = $urandom_range(1, 32);
        // Magnitude with its leading one at bit width-1
        v = ($urandom & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1));
        r.int_value     = $urandom;
        r.pow2_exponent = 10'($urandom);
        if (pick <= 5)
        begin
            // Land the biased exponent near underflow, overflow or anywhere normal
            case ($urandom_range(0, 3))
                0: target = int'($urandom_range(0, 40)) - 30;
                1: target = int'($urandom_range(245, 262));
                2: target = int'($urandom_range(1, 254));
                default: target = int'($urandom_range(0, 2));
            endcase
            e = target - (width - 1) - i2f_pkg::EXP_BIAS;
            if (e < -512)
                e = -512;
            if (e > 511)
                e = 511;
            r.int_value     = $urandom_range(0, 1) ? -v : v;
            r.pow2_exponent = 10'(e);
        end
        else if (pick == 8)
        begin
            // Exact halfway pattern below the 24 kept bits
            width    = $urandom_range(25, 32);
            v        = ($urandom & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1));
            low_mask = (32'd1 << (width - 24)) - 32'd1;
            v        = (v & ~low_mask) | (32'd1 << (width - 25));
            r.int_value     = $urandom_range(0, 1) ? -v : v;
            r.pow2_exponent = 10'(int'($urandom_range(0, 80)) - 40);
        end
        else if (pick == 9)
        begin
            r.int_value = int'($urandom_range(0, 2)) - 1;
        end
        return r;
    endfunction

    // Hold the next phase back until every item is accepted and answered
    task automatic wait_for_drain();
        while (pending_q.size() != 0 || s_axis_tvalid || float_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the next pending item once the current one is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, pending_q.pop_front()};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input accept, check on output accept, drive tready
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                float_expect_q.push_back(to_float32_bits(s_axis_tdata[31:0],
                                                         s_axis_tdata[41:32]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (float_expect_q.size() == 0)
                begin
                    $error("float_bits: unexpected result, expected none, actual %h",
                           m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want_bits = float_expect_q.pop_front();
                    if (m_axis_tdata !== want_bits)
                    begin
                        $error("float_bits: expected %h, actual %h", want_bits, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed items, then random phases
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero gives +0 whatever the exponent
        queue_conversion(32'sd0, 10'sd0);
        queue_conversion(32'sd0, 10'sd511);
        queue_conversion(32'sd0, -10'sd512);
        // Unit values and the integer extremes
        queue_conversion(32'sd1, 10'sd0);
        queue_conversion(-32'sd1, 10'sd0);
        queue_conversion(32'h7fff_ffff, 10'sd0);
        queue_conversion(32'h8000_0000, 10'sd0);
        queue_conversion(32'h1234_5678, 10'sd511);
        queue_conversion(32'h7fff_ffff, -10'sd512);
        // Underflow to a zero that keeps the integer's sign
        queue_conversion(32'h8000_0000, -10'sd512);
        queue_conversion(-32'sd1, -10'sd151);
        // Largest power of two, then overflow that saturates to signed infinity
        queue_conversion(32'sd1, 10'sd127);
        queue_conversion(32'sd1, 10'sd128);
        queue_conversion(-32'sd1, 10'sd511);
        queue_conversion(32'h8000_0000, 10'sd511);
        // Largest finite, then a rounding carry that pushes it to infinity
        queue_conversion(32'h00ff_ffff, 10'sd104);
        queue_conversion(32'h01ff_ffff, 10'sd104);
        // Smallest subnormal, halfway below it, and three quarters of it
        queue_conversion(32'sd1, -10'sd149);
        queue_conversion(32'sd1, -10'sd150);
        queue_conversion(32'sd3, -10'sd151);
        // Subnormal that rounds up into the smallest normal, and that normal
        queue_conversion(32'h00ff_ffff, -10'sd150);
        queue_conversion(32'sd1, -10'sd126);
        // Ties on the normal path: one rounds down to even, one up
        queue_conversion(32'h0100_0001, 10'sd0);
        queue_conversion(-32'sh0100_0003, 10'sd0);
        // Pause the source until every directed result is back
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            src_gap_pct    = SRC_GAP_PCT[phase];
            sink_stall_pct = SINK_STALL_PCT[phase];
            repeat (ITEMS_PER_PHASE) pending_q.push_back(draw_conversion());
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && float_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
